// File: design/rk4_pkg.sv
// shared types, constants and micro-op program of the rk4 oscillator step
package rk4_pkg;

  localparam int unsigned FieldW  = 32;
  localparam int unsigned CoefW   = 31;
  localparam int unsigned StepW   = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] CFG_DAMPING   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STIFFNESS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIME_STEP = 2'd2;

  localparam logic [CoefW-1:0] DampingReset   = 31'd8388608;
  localparam logic [CoefW-1:0] StiffnessReset = 31'd33554432;
  localparam logic [StepW-1:0] TimeStepReset  = 24'd167772;

  localparam int unsigned PcW     = 6;
  localparam int unsigned ProgLen = 48;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_NEG,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [3:0] {
    R_X,
    R_V,
    R_PX,
    R_PV,
    R_KX,
    R_KV,
    R_SX,
    R_SV,
    R_M,
    R_A,
    R_C,
    R_K,
    R_DT,
    R_ZERO
  } opnd_e;

  typedef struct packed {
    op_e   op;
    opnd_e dst;
    opnd_e src_a;
    opnd_e src_b;
    logic  half;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } seq_state_e;

  typedef struct packed {
    logic start;
    logic half;
  } mul_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } unit_rsp_t;

  function automatic uop_t mk_uop(op_e op, opnd_e dst, opnd_e a, opnd_e b, logic half);
    uop_t u;
    u.op    = op;
    u.dst   = dst;
    u.src_a = a;
    u.src_b = b;
    u.half  = half;
    return u;
  endfunction

  // one rk4 step: k1, three probes with k2..k4, weighted sum, divide by six
  function automatic uop_t prog(logic [PcW-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:         u = mk_uop(OP_MUL, R_M,  R_C,  R_V,    1'b0);
      6'd1:         u = mk_uop(OP_MUL, R_A,  R_K,  R_X,    1'b0);
      6'd2:         u = mk_uop(OP_ADD, R_A,  R_M,  R_A,    1'b0);
      6'd3:         u = mk_uop(OP_NEG, R_KV, R_A,  R_ZERO, 1'b0);
      6'd4:         u = mk_uop(OP_ADD, R_SV, R_KV, R_ZERO, 1'b0);
      6'd5:         u = mk_uop(OP_ADD, R_SX, R_V,  R_ZERO, 1'b0);
      6'd6:         u = mk_uop(OP_MUL, R_M,  R_DT, R_V,    1'b1);
      6'd7:         u = mk_uop(OP_ADD, R_PX, R_X,  R_M,    1'b0);
      6'd8:         u = mk_uop(OP_MUL, R_M,  R_DT, R_KV,   1'b1);
      6'd9:         u = mk_uop(OP_ADD, R_PV, R_V,  R_M,    1'b0);
      6'd10, 6'd23: u = mk_uop(OP_MUL, R_M,  R_C,  R_PV,   1'b0);
      6'd11, 6'd24: u = mk_uop(OP_MUL, R_A,  R_K,  R_PX,   1'b0);
      6'd12, 6'd25: u = mk_uop(OP_ADD, R_A,  R_M,  R_A,    1'b0);
      6'd13, 6'd26: u = mk_uop(OP_NEG, R_KV, R_A,  R_ZERO, 1'b0);
      6'd14, 6'd27: u = mk_uop(OP_ADD, R_KX, R_PV, R_ZERO, 1'b0);
      6'd15, 6'd28: u = mk_uop(OP_ADD, R_A,  R_KX, R_KX,   1'b0);
      6'd16, 6'd29: u = mk_uop(OP_ADD, R_SX, R_SX, R_A,    1'b0);
      6'd17, 6'd30: u = mk_uop(OP_ADD, R_A,  R_KV, R_KV,   1'b0);
      6'd18, 6'd31: u = mk_uop(OP_ADD, R_SV, R_SV, R_A,    1'b0);
      6'd19:        u = mk_uop(OP_MUL, R_M,  R_DT, R_KX,   1'b1);
      6'd20:        u = mk_uop(OP_ADD, R_PX, R_X,  R_M,    1'b0);
      6'd21:        u = mk_uop(OP_MUL, R_M,  R_DT, R_KV,   1'b1);
      6'd22:        u = mk_uop(OP_ADD, R_PV, R_V,  R_M,    1'b0);
      6'd32:        u = mk_uop(OP_MUL, R_M,  R_DT, R_KX,   1'b0);
      6'd33:        u = mk_uop(OP_ADD, R_PX, R_X,  R_M,    1'b0);
      6'd34:        u = mk_uop(OP_MUL, R_M,  R_DT, R_KV,   1'b0);
      6'd35:        u = mk_uop(OP_ADD, R_PV, R_V,  R_M,    1'b0);
      6'd36:        u = mk_uop(OP_MUL, R_M,  R_C,  R_PV,   1'b0);
      6'd37:        u = mk_uop(OP_MUL, R_A,  R_K,  R_PX,   1'b0);
      6'd38:        u = mk_uop(OP_ADD, R_A,  R_M,  R_A,    1'b0);
      6'd39:        u = mk_uop(OP_NEG, R_KV, R_A,  R_ZERO, 1'b0);
      6'd40:        u = mk_uop(OP_ADD, R_SX, R_SX, R_PV,   1'b0);
      6'd41:        u = mk_uop(OP_ADD, R_SV, R_SV, R_KV,   1'b0);
      6'd42:        u = mk_uop(OP_MUL, R_M,  R_DT, R_SX,   1'b0);
      6'd43:        u = mk_uop(OP_DIV, R_A,  R_M,  R_ZERO, 1'b0);
      6'd44:        u = mk_uop(OP_ADD, R_X,  R_X,  R_A,    1'b0);
      6'd45:        u = mk_uop(OP_MUL, R_M,  R_DT, R_SV,   1'b0);
      6'd46:        u = mk_uop(OP_DIV, R_A,  R_M,  R_ZERO, 1'b0);
      6'd47:        u = mk_uop(OP_ADD, R_V,  R_V,  R_A,    1'b0);
      default:      u = mk_uop(OP_ADD, R_A,  R_ZERO, R_ZERO, 1'b0);
    endcase
    return u;
  endfunction

endpackage

// File: design/rk4_mul.sv
// multi-cycle saturating fixed-point multiplier, 32x32 partial products
module rk4_mul import rk4_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 24,
  parameter int unsigned WORD_WIDTH    = 32,
  parameter int unsigned OP_WIDTH      = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mul_req_t                     req_i,
  input  logic signed [OP_WIDTH-1:0]   a_i,
  input  logic signed [OP_WIDTH-1:0]   b_i,
  output unit_rsp_t                    rsp_o,
  output logic signed [WORD_WIDTH-1:0] result_o
);

  localparam int unsigned DigW   = 32;
  localparam int unsigned NumDig = (OP_WIDTH + DigW - 1) / DigW;
  localparam int unsigned PadW   = NumDig * DigW;
  localparam int unsigned AccW   = 2 * PadW;
  localparam int unsigned IdxW   = (NumDig > 1) ? $clog2(NumDig) : 1;
  localparam int unsigned ShW    = 5;

  localparam logic [AccW-1:0] WMaxA  = (AccW'(1) << (WORD_WIDTH - 1)) - AccW'(1);
  localparam logic [AccW-1:0] LimitA = AccW'(1) << (WORD_WIDTH - 1);
  localparam logic [WORD_WIDTH-1:0] WMax = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic [WORD_WIDTH-1:0] WMin = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  logic [PadW-1:0]     ua_q, ub_q;
  logic                neg_q, half_q;
  logic [AccW-1:0]     acc_q;
  logic [IdxW-1:0]     i_q, j_q;
  logic                busy_q, norm_q;

  logic [OP_WIDTH-1:0] mag_a, mag_b;
  logic [2*DigW-1:0]   pp;
  logic [AccW-1:0]     pp_sh;
  logic                last_dig;
  logic [ShW-1:0]      shamt;
  logic [AccW-1:0]     quo, quo_up;
  logic                rem_nz;
  logic                ovf;

  always_comb begin
    mag_a    = a_i[OP_WIDTH-1] ? (~a_i + 1'b1) : a_i;
    mag_b    = b_i[OP_WIDTH-1] ? (~b_i + 1'b1) : b_i;
    pp       = ua_q[DigW*i_q +: DigW] * ub_q[DigW*j_q +: DigW];
    pp_sh    = AccW'(pp) << (DigW * (int'(i_q) + int'(j_q)));
    last_dig = (i_q == IdxW'(NumDig - 1)) && (j_q == IdxW'(NumDig - 1));
  end

  // floor division by 2^(fraction+half), then saturate to the word
  always_comb begin
    shamt  = ShW'(FRACTION_BITS) + ShW'(half_q);
    quo    = acc_q >> shamt;
    rem_nz = |(acc_q & ~({AccW{1'b1}} << shamt));
    quo_up = quo + AccW'(rem_nz);
    ovf    = 1'b0;
    if (!neg_q) begin
      if (quo > WMaxA) begin
        ovf      = 1'b1;
        result_o = WMax;
      end else begin
        result_o = quo[WORD_WIDTH-1:0];
      end
    end else begin
      if (quo_up > LimitA) begin
        ovf      = 1'b1;
        result_o = WMin;
      end else begin
        result_o = ~quo_up[WORD_WIDTH-1:0] + 1'b1;
      end
    end
    rsp_o.done = norm_q;
    rsp_o.sat  = norm_q & ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      norm_q <= 1'b0;
    end else begin
      norm_q <= busy_q & last_dig;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && last_dig) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ua_q   <= PadW'(mag_a);
      ub_q   <= PadW'(mag_b);
      neg_q  <= a_i[OP_WIDTH-1] ^ b_i[OP_WIDTH-1];
      half_q <= req_i.half;
      acc_q  <= '0;
      i_q    <= '0;
      j_q    <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
      if (j_q == IdxW'(NumDig - 1)) begin
        j_q <= '0;
        if (!last_dig) begin
          i_q <= i_q + 1'b1;
        end
      end else begin
        j_q <= j_q + 1'b1;
      end
    end
  end

endmodule

// File: design/rk4_div6.sv
// divide by six, truncating toward zero, one byte of dividend per cycle
module rk4_div6 import rk4_pkg::*; #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [WORD_WIDTH-1:0] dividend_i,
  output unit_rsp_t                    rsp_o,
  output logic signed [WORD_WIDTH-1:0] quotient_o
);

  localparam int unsigned NumByte = (WORD_WIDTH + 7) / 8;
  localparam int unsigned PadW    = NumByte * 8;
  localparam int unsigned CntW    = $clog2(NumByte + 1);

  logic [PadW-1:0]       sh_q, sh_d;
  logic [2:0]            rem_q, rem_d;
  logic                  neg_q, busy_q;
  logic [CntW-1:0]       cnt_q;

  logic [WORD_WIDTH-1:0] mag;
  logic [7:0]            byte_in, qbyte;
  logic [2:0]            r;
  logic [3:0]            t;
  logic                  done;

  always_comb begin
    mag     = dividend_i[WORD_WIDTH-1] ? (~dividend_i + 1'b1) : dividend_i;
    byte_in = sh_q[PadW-1 -: 8];
    r       = rem_q;
    qbyte   = '0;
    for (int b = 7; b >= 0; b--) begin
      t = {r, byte_in[b]};
      if (t >= 4'd6) begin
        r        = 3'(t - 4'd6);
        qbyte[b] = 1'b1;
      end else begin
        r        = t[2:0];
        qbyte[b] = 1'b0;
      end
    end
    rem_d = r;
    sh_d  = {sh_q[PadW-9:0], qbyte};
    done  = busy_q && (cnt_q == CntW'(NumByte));
    quotient_o = neg_q ? (~sh_q[WORD_WIDTH-1:0] + 1'b1) : sh_q[WORD_WIDTH-1:0];
    rsp_o.done = done;
    rsp_o.sat  = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= PadW'(mag);
      rem_q <= '0;
      neg_q <= dividend_i[WORD_WIDTH-1];
    end else if (busy_q && !done) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

endmodule

// File: design/rk4_damped_oscillator_step.sv
// top level: rk4 damped oscillator step with microcoded sequencer and shared units
// load item: the sequencer enters its done state, and out_valid_o rises when the output register is loaded
// step item: 48 micro-ops, 30 add/negate, 16 multiplies and 2 divides by six, then
//   the result goes into the output register
// one item at a time; the shared multiplier sets the step time
// reset: position 1.0, velocity 0, coefficients at defaults, output register empty
module rk4_damped_oscillator_step import rk4_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 24,
  parameter int unsigned WORD_WIDTH    = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       mode_i,
  input  logic signed [FieldW-1:0]   load_position_i,
  input  logic signed [FieldW-1:0]   load_velocity_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [FieldW-1:0]   position_o,
  output logic signed [FieldW-1:0]   velocity_o,
  output logic                       saturated_o
);

  localparam int unsigned OpW = (WORD_WIDTH > FieldW) ? WORD_WIDTH : FieldW;
  localparam logic signed [WORD_WIDTH-1:0] WMax = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic signed [WORD_WIDTH-1:0] WMin = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam logic signed [WORD_WIDTH-1:0] PosReset = WORD_WIDTH'(1) << FRACTION_BITS;

  seq_state_e state_q, state_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic           issued_q, issued_d;
  logic           sat_q, sat_d;

  logic [CoefW-1:0] c_q, k_q;
  logic [StepW-1:0] dt_q;

  logic signed [WORD_WIDTH-1:0] x_q, v_q, px_q, pv_q, kx_q, kv_q, sx_q, sv_q, m_q, a_q;

  logic                         out_valid_q;
  logic signed [FieldW-1:0]     pos_q, vel_q;
  logic                         osat_q;

  uop_t                         uop;
  logic signed [OpW-1:0]        opa, opb;
  logic signed [WORD_WIDTH-1:0] a_w, b_w;
  logic [WORD_WIDTH:0]          sum;
  logic signed [WORD_WIDTH-1:0] alu_res;
  logic                         alu_sat;
  logic                         op_done, wr_en;

  mul_req_t                     mul_req;
  unit_rsp_t                    mul_rsp, div_rsp;
  logic signed [WORD_WIDTH-1:0] mul_res, div_res;
  logic                         div_start;

  logic                         load_en;
  logic signed [OpW-1:0]        ld_pos_ext, ld_vel_ext;
  logic signed [WORD_WIDTH-1:0] ld_pos, ld_vel;
  logic                         ld_sat;
  logic                         out_load;

  assign uop = prog(pc_q);

  always_comb begin
    case (uop.src_a)
      R_X:     opa = OpW'(x_q);
      R_V:     opa = OpW'(v_q);
      R_PX:    opa = OpW'(px_q);
      R_PV:    opa = OpW'(pv_q);
      R_KX:    opa = OpW'(kx_q);
      R_KV:    opa = OpW'(kv_q);
      R_SX:    opa = OpW'(sx_q);
      R_SV:    opa = OpW'(sv_q);
      R_M:     opa = OpW'(m_q);
      R_A:     opa = OpW'(a_q);
      R_C:     opa = OpW'(c_q);
      R_K:     opa = OpW'(k_q);
      R_DT:    opa = OpW'(dt_q);
      default: opa = '0;
    endcase
    case (uop.src_b)
      R_X:     opb = OpW'(x_q);
      R_V:     opb = OpW'(v_q);
      R_PX:    opb = OpW'(px_q);
      R_PV:    opb = OpW'(pv_q);
      R_KX:    opb = OpW'(kx_q);
      R_KV:    opb = OpW'(kv_q);
      R_SX:    opb = OpW'(sx_q);
      R_SV:    opb = OpW'(sv_q);
      R_M:     opb = OpW'(m_q);
      R_A:     opb = OpW'(a_q);
      R_C:     opb = OpW'(c_q);
      R_K:     opb = OpW'(k_q);
      R_DT:    opb = OpW'(dt_q);
      default: opb = '0;
    endcase
  end

  assign mul_req.start = (state_q == ST_RUN) && (uop.op == OP_MUL) && !issued_q;
  assign mul_req.half  = uop.half;
  assign div_start     = (state_q == ST_RUN) && (uop.op == OP_DIV) && !issued_q;

  rk4_mul #(
    .FRACTION_BITS (FRACTION_BITS),
    .WORD_WIDTH    (WORD_WIDTH),
    .OP_WIDTH      (OpW)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mul_req),
    .a_i      (opa),
    .b_i      (opb),
    .rsp_o    (mul_rsp),
    .result_o (mul_res)
  );

  rk4_div6 #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_div6 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_w),
    .rsp_o      (div_rsp),
    .quotient_o (div_res)
  );

  // saturating add and negate, combinational; multiply and divide results pass through from their units
  always_comb begin
    a_w     = opa[WORD_WIDTH-1:0];
    b_w     = opb[WORD_WIDTH-1:0];
    sum     = {a_w[WORD_WIDTH-1], a_w} + {b_w[WORD_WIDTH-1], b_w};
    alu_res = '0;
    alu_sat = 1'b0;
    op_done = 1'b0;
    case (uop.op)
      OP_ADD: begin
        op_done = 1'b1;
        if (sum[WORD_WIDTH] != sum[WORD_WIDTH-1]) begin
          alu_sat = 1'b1;
          alu_res = sum[WORD_WIDTH] ? WMin : WMax;
        end else begin
          alu_res = sum[WORD_WIDTH-1:0];
        end
      end
      OP_NEG: begin
        op_done = 1'b1;
        if (a_w == WMin) begin
          alu_sat = 1'b1;
          alu_res = WMax;
        end else begin
          alu_res = ~a_w + 1'b1;
        end
      end
      OP_MUL: begin
        op_done = mul_rsp.done;
        alu_sat = mul_rsp.sat;
        alu_res = mul_res;
      end
      OP_DIV: begin
        op_done = div_rsp.done;
        alu_sat = div_rsp.sat;
        alu_res = div_res;
      end
      default: begin
        op_done = 1'b1;
      end
    endcase
    wr_en = (state_q == ST_RUN) && op_done;
  end

  // load values clip to the word range
  always_comb begin
    ld_pos_ext = OpW'(load_position_i);
    ld_vel_ext = OpW'(load_velocity_i);
    ld_sat     = 1'b0;
    if (ld_pos_ext > OpW'(WMax)) begin
      ld_pos = WMax;
      ld_sat = 1'b1;
    end else if (ld_pos_ext < OpW'(WMin)) begin
      ld_pos = WMin;
      ld_sat = 1'b1;
    end else begin
      ld_pos = ld_pos_ext[WORD_WIDTH-1:0];
    end
    if (ld_vel_ext > OpW'(WMax)) begin
      ld_vel = WMax;
      ld_sat = 1'b1;
    end else if (ld_vel_ext < OpW'(WMin)) begin
      ld_vel = WMin;
      ld_sat = 1'b1;
    end else begin
      ld_vel = ld_vel_ext[WORD_WIDTH-1:0];
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign load_en     = in_ready_o && in_valid_i && mode_i;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d  = state_q;
    pc_d     = pc_q;
    issued_d = issued_q;
    sat_d    = sat_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (mode_i) begin
            sat_d   = ld_sat;
            state_d = ST_DONE;
          end else begin
            sat_d    = 1'b0;
            pc_d     = '0;
            issued_d = 1'b0;
            state_d  = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (wr_en) begin
          sat_d    = sat_q | alu_sat;
          issued_d = 1'b0;
          if (pc_q == PcW'(ProgLen - 1)) begin
            state_d = ST_DONE;
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end else if (mul_req.start || div_start) begin
          issued_d = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      issued_q    <= 1'b0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      issued_q <= issued_d;
      sat_q    <= sat_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q  <= DampingReset;
      k_q  <= StiffnessReset;
      dt_q <= TimeStepReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DAMPING:   c_q  <= cfg_data_i[CoefW-1:0];
        CFG_STIFFNESS: k_q  <= cfg_data_i[CoefW-1:0];
        CFG_TIME_STEP: dt_q <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= PosReset;
      v_q <= '0;
    end else if (load_en) begin
      x_q <= ld_pos;
      v_q <= ld_vel;
    end else if (wr_en && uop.dst == R_X) begin
      x_q <= alu_res;
    end else if (wr_en && uop.dst == R_V) begin
      v_q <= alu_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      case (uop.dst)
        R_PX:    px_q <= alu_res;
        R_PV:    pv_q <= alu_res;
        R_KX:    kx_q <= alu_res;
        R_KV:    kv_q <= alu_res;
        R_SX:    sx_q <= alu_res;
        R_SV:    sv_q <= alu_res;
        R_M:     m_q  <= alu_res;
        R_A:     a_q  <= alu_res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_q  <= FieldW'(x_q);
      vel_q  <= FieldW'(v_q);
      osat_q <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;
  assign velocity_o  = vel_q;
  assign saturated_o = osat_q;

endmodule

// File: design/rk4_checker.sv
// port-level checks of the rk4 oscillator step, bound to the top level
module rk4_checker import rk4_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     mode_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [FieldW-1:0] position_o,
  input logic signed [FieldW-1:0] velocity_o,
  input logic                     saturated_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(position_o) && $stable(velocity_o) && $stable(saturated_o))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while previous one in flight");

  a_step_multicycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !mode_i |=> ##1 !in_ready_o)
    else $error("step item finished too early");

  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && mode_i && !out_valid_o |=> ##1 out_valid_o)
    else $error("load item result missing");

endmodule

bind rk4_damped_oscillator_step rk4_checker u_rk4_checker (.*);

// File: tb/tb.sv
// self-checking testbench for the rk4 damped oscillator step block
module tb;
  import rk4_pkg::*;

  localparam int FRAC = 24;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  localparam logic MODE_STEP = 1'b0;
  localparam logic MODE_LOAD = 1'b1;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  localparam logic [31:0] Q_ONE  = 32'h0100_0000;
  localparam logic [31:0] Q_HALF = 32'h0080_0000;
  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;

  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 225;

  typedef struct packed {
    logic signed [FieldW-1:0] pos;
    logic signed [FieldW-1:0] vel;
    logic                     sat;
  } osc_state_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        mode;
    logic [31:0] a;
    logic [31:0] b;
    logic        typed;
    osc_state_t  want;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i;
  logic [CfgDataW-1:0]      cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     mode_i;
  logic signed [FieldW-1:0] load_position_i;
  logic signed [FieldW-1:0] load_velocity_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [FieldW-1:0] position_o;
  logic signed [FieldW-1:0] velocity_o;
  logic                     saturated_o;

  logic [CoefW-1:0]         damp_coef;
  logic [CoefW-1:0]         stiff_coef;
  logic [StepW-1:0]         dt_step;
  logic signed [FieldW-1:0] osc_pos;
  logic signed [FieldW-1:0] osc_vel;
  logic                     sat_hit;

  osc_state_t expected_states[$];
  osc_state_t want_state;
  stim_row_t  directed_rows[$];
  int         mismatch_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  rk4_damped_oscillator_step uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .load_position_i(load_position_i),
    .load_velocity_i(load_velocity_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .position_o     (position_o),
    .velocity_o     (velocity_o),
    .saturated_o    (saturated_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint clamp_word(longint a);
    if (a > WORD_MAX) begin
      sat_hit = 1'b1;
      return WORD_MAX;
    end
    if (a < WORD_MIN) begin
      sat_hit = 1'b1;
      return WORD_MIN;
    end
    return a;
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clamp_word(a + b);
  endfunction

  function automatic longint fx_neg(longint a);
    return clamp_word(-a);
  endfunction

  // exact product, floor on the shift
  function automatic longint fx_mul(longint a, longint b, int shift);
    return clamp_word((a * b) >>> shift);
  endfunction

  function automatic longint accel(longint x, longint v);
    return fx_neg(fx_add(fx_mul(damp_coef, v, FRAC), fx_mul(stiff_coef, x, FRAC)));
  endfunction

  function automatic osc_state_t apply_item(logic mode, logic [31:0] lp, logic [31:0] lv);
    longint x, v, dt, px, pv;
    longint k1x, k1v, k2x, k2v, k3x, k3v, k4x, k4v, sx, sv;
    osc_state_t r;
    sat_hit = 1'b0;
    if (mode == MODE_LOAD) begin
      osc_pos = lp;
      osc_vel = lv;
    end else begin
      x = osc_pos;
      v = osc_vel;
      dt = dt_step;
      k1x = v;
      k1v = accel(x, v);
      px = fx_add(x, fx_mul(dt, k1x, FRAC + 1));
      pv = fx_add(v, fx_mul(dt, k1v, FRAC + 1));
      k2x = pv;
      k2v = accel(px, pv);
      px = fx_add(x, fx_mul(dt, k2x, FRAC + 1));
      pv = fx_add(v, fx_mul(dt, k2v, FRAC + 1));
      k3x = pv;
      k3v = accel(px, pv);
      px = fx_add(x, fx_mul(dt, k3x, FRAC));
      pv = fx_add(v, fx_mul(dt, k3v, FRAC));
      k4x = pv;
      k4v = accel(px, pv);
      sx = fx_add(fx_add(fx_add(k1x, fx_add(k2x, k2x)), fx_add(k3x, k3x)), k4x);
      sv = fx_add(fx_add(fx_add(k1v, fx_add(k2v, k2v)), fx_add(k3v, k3v)), k4v);
      // divide truncates toward zero
      osc_pos = fx_add(x, fx_mul(dt, sx, FRAC) / 6);
      osc_vel = fx_add(v, fx_mul(dt, sv, FRAC) / 6);
    end
    r.pos = osc_pos;
    r.vel = osc_vel;
    r.sat = sat_hit;
    return r;
  endfunction

  function automatic stim_row_t mk_row(row_kind_e kind, logic mode, logic [31:0] a,
                                       logic [31:0] b, logic typed, logic [31:0] wp,
                                       logic [31:0] wv, logic ws);
    stim_row_t r;
    r.kind = kind;
    r.mode = mode;
    r.a = a;
    r.b = b;
    r.typed = typed;
    r.want.pos = wp;
    r.want.vel = wv;
    r.want.sat = ws;
    return r;
  endfunction

  function automatic logic [31:0] rand_q824();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(32'h0800_0000) - 32'h0400_0000;
      6: return $urandom();
      7: return Q_MAX;
      8: return Q_MIN;
      default: return '0;
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s expected %h got %h", $time, what, want, got);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DAMPING:   damp_coef = data;
      CFG_STIFFNESS: stiff_coef = data;
      CFG_TIME_STEP: dt_step = data[StepW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_item(input logic mode, input logic [31:0] lp, input logic [31:0] lv,
                           input logic typed, input osc_state_t want);
    osc_state_t predicted;
    cfg_valid_i <= 1'b0;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    load_position_i <= lp;
    load_velocity_i <= lv;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_item(mode, lp, lv);
    expected_states.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_states.size() == 0) begin
        note_mismatch("unexpected item, position", '0, position_o);
      end else begin
        want_state = expected_states.pop_front();
        if (position_o !== want_state.pos)
          note_mismatch("position", want_state.pos, position_o);
        if (velocity_o !== want_state.vel)
          note_mismatch("velocity", want_state.vel, velocity_o);
        if (saturated_o !== want_state.sat)
          note_mismatch("saturated", want_state.sat, saturated_o);
      end
    end
  end

  initial begin
    stim_row_t row;
    logic [StepW-1:0] dt_bits;
    logic item_mode;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_DAMPING;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    mode_i <= MODE_STEP;
    load_position_i <= '0;
    load_velocity_i <= '0;
    out_ready_i <= 1'b0;
    damp_coef = DampingReset;
    stiff_coef = StiffnessReset;
    dt_step = TimeStepReset;
    osc_pos = Q_ONE;
    osc_vel = '0;

    directed_rows.push_back(mk_row(ROW_ITEM, MODE_STEP, '0, '0, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_LOAD, Q_MAX, Q_MIN, 1'b1, Q_MAX, Q_MIN, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_STEP, Q_MAX, Q_MAX, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_LOAD, Q_MIN, Q_MAX, 1'b1, Q_MIN, Q_MAX, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_STEP, '1, '1, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_LOAD, '0, '0, 1'b1, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_STEP, '0, '0, 1'b1, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_LOAD, '1, 32'd1, 1'b1, '1, 32'd1, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_STEP, '0, '0, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_LOAD, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1,
                                   32'hAAAA_AAAA, 32'h5555_5555, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_STEP, '0, '0, 1'b0, '0, '0, 1'b0));
    // zero time step holds the state
    directed_rows.push_back(mk_row(ROW_REG, MODE_STEP, CFG_TIME_STEP, '0, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_LOAD, Q_ONE, Q_HALF, 1'b1, Q_ONE, Q_HALF, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_STEP, '0, '0, 1'b1, Q_ONE, Q_HALF, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_LOAD, Q_MAX, Q_MAX, 1'b1, Q_MAX, Q_MAX, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_STEP, '0, '0, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_REG, MODE_STEP, CFG_TIME_STEP, 32'hFF_FFFF, 1'b0,
                                   '0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_REG, MODE_STEP, CFG_DAMPING, Q_MAX, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_REG, MODE_STEP, CFG_STIFFNESS, Q_MAX, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_LOAD, Q_ONE, -Q_ONE, 1'b1, Q_ONE, -Q_ONE, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_STEP, '0, '0, 1'b0, '0, '0, 1'b0));
    // write to an unused index changes nothing
    directed_rows.push_back(mk_row(ROW_REG, MODE_STEP, CFG_UNUSED, Q_MAX, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_STEP, '0, '0, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_REG, MODE_STEP, CFG_DAMPING, '0, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_REG, MODE_STEP, CFG_STIFFNESS, '0, 1'b0, '0, '0, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_LOAD, Q_ONE, Q_ONE, 1'b1, Q_ONE, Q_ONE, 1'b0));
    directed_rows.push_back(mk_row(ROW_ITEM, MODE_STEP, '0, '0, 1'b0, '0, '0, 1'b0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG)
        write_reg(row.a[CfgIdxW-1:0], row.b[CfgDataW-1:0]);
      else
        send_item(row.mode, row.a, row.b, row.typed, row.want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(CFG_DAMPING, DampingReset);
          write_reg(CFG_STIFFNESS, StiffnessReset);
          write_reg(CFG_TIME_STEP, TimeStepReset);
        end
        2: begin
          write_reg(CFG_DAMPING, Q_MAX);
          write_reg(CFG_STIFFNESS, Q_MAX);
          write_reg(CFG_TIME_STEP, 24'hFF_FFFF);
        end
        3: begin
          write_reg(CFG_DAMPING, '0);
          write_reg(CFG_STIFFNESS, '0);
          write_reg(CFG_TIME_STEP, 24'd1);
        end
        4: begin
          write_reg(CFG_DAMPING, $urandom_range(32'h0400_0000));
          write_reg(CFG_STIFFNESS, $urandom_range(32'h1000_0000));
          write_reg(CFG_TIME_STEP, '0);
        end
        5: begin
          write_reg(CFG_DAMPING, $urandom());
          write_reg(CFG_STIFFNESS, $urandom());
          write_reg(CFG_TIME_STEP, $urandom_range(24'hFF_FFFF));
        end
        7: begin
          // bits above the time step width are dropped
          dt_bits = $urandom_range(1, 24'h19_9999);
          write_reg(CFG_DAMPING, $urandom_range(32'h0400_0000));
          write_reg(CFG_STIFFNESS, $urandom_range(32'h1000_0000));
          write_reg(CFG_TIME_STEP, {7'h7F, dt_bits});
          write_reg(CFG_UNUSED, $urandom());
        end
        default: begin
          write_reg(CFG_DAMPING, $urandom_range(32'h0400_0000));
          write_reg(CFG_STIFFNESS, $urandom_range(32'h1000_0000));
          write_reg(CFG_TIME_STEP, $urandom_range(1, 24'h19_9999));
        end
      endcase
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct = 21;
          recv_stall_pct = 21;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        item_mode = ($urandom_range(99) < 8) ? MODE_LOAD : MODE_STEP;
        if (item_mode == MODE_LOAD)
          send_item(MODE_LOAD, rand_q824(), rand_q824(), 1'b0, '0);
        else
          send_item(MODE_STEP, $urandom(), $urandom(), 1'b0, '0);
        if ($urandom_range(149) == 0) drain();
      end
    end

    drain();
    repeat (150) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
